### hw/rtl/ifc_pkg.sv
// ----------------------------------------------------------------------------
// ifc_pkg
// Types and constants for the IBM hex / IEEE-754 single word converter.
// ----------------------------------------------------------------------------
package ifc_pkg;

    // direction codes
    localparam logic FUNC_IBM2IEEE = 1'b0;
    localparam logic FUNC_IEEE2IBM = 1'b1;

    // status codes
    localparam logic [1:0] ST_NORMAL = 2'd0;
    localparam logic [1:0] ST_SAT    = 2'd1;
    localparam logic [1:0] ST_UNDER  = 2'd2;
    localparam logic [1:0] ST_NAN    = 2'd3;

    // fixed words
    localparam logic [31:0] QNAN_WORD    = 32'h7FC0_0000;
    localparam logic [30:0] MAX_FINITE   = 31'h7F7F_FFFF;
    localparam logic [9:0]  IBM_EXP_BIAS = 10'd130;
    localparam logic [9:0]  IEEE_EXP_MAX = 10'd254;
    localparam logic [6:0]  IBM_EXP_OFS  = 7'd32;

    typedef struct packed {
        logic        func;
        logic [31:0] word_in;
    } t_in_item;

    typedef struct packed {
        logic [31:0] word_out;
        logic [1:0]  status;
    } t_out_item;

    // reverse byte order of a word
    function automatic logic [31:0] bswap32(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

endpackage

### hw/rtl/ibm_ieee_float32_convert_top.sv
// ----------------------------------------------------------------------------
// ibm_ieee_float32_convert_top
// Converts one 32-bit word per cycle between IBM hex single and IEEE single.
// The start transfer reaches the result strobe through r_v1, r_v2 and r_v3.
// Throughput: one item per cycle; busy stays low, the three register stages
// (swap / leading-zero count / normalise and pack) hold one item each.
// Reset: synchronous, active low; clears stage valids and sets r_swap.
// ----------------------------------------------------------------------------
module ibm_ieee_float32_convert_top
    import ifc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    output logic      o_busy,
    input  t_in_item  i_item,
    output logic      o_strobe,
    output t_out_item o_result,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    // configuration register
    logic r_swap;

    // stage 1: source word, byte-swapped on the IBM side when r_swap is set
    logic        r_v1, r_func1, r_swap1;
    logic [31:0] r_w1;
    logic [31:0] n_w1;

    // stage 2: IBM fields with leading-zero count, IEEE-to-IBM result
    logic        r_v2, r_func2, r_swap2;
    logic        r_sign2, r_zword2, r_zfrac2;
    logic [6:0]  r_exp2;
    logic [23:0] r_frac2;
    logic [4:0]  r_lzc2;
    logic [31:0] r_ibm2;
    logic [4:0]  n_lzc2;
    logic [31:0] n_ibm2;
    logic [8:0]  u_exp;
    logic [1:0]  u_shift;
    logic [8:0]  u_aligned;
    logic [6:0]  u_hexexp;

    // stage 3: result register
    logic        r_v3;
    t_out_item   r_res3;
    t_out_item   n_res3;
    logic signed [9:0] e_bin;
    logic [23:0] norm_frac;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign o_strobe    = r_v3;
    assign o_result    = r_res3;

    // configuration transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_swap <= 1'b1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_swap <= i_cfg_data;
        end
    end

    // stage 1 input swap
    always_comb begin
        if (i_item.func == FUNC_IBM2IEEE && r_swap) begin
            n_w1 = bswap32(i_item.word_in);
        end else begin
            n_w1 = i_item.word_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start && !o_busy;
        end
        r_func1 <= i_item.func;
        r_swap1 <= r_swap;
        r_w1    <= n_w1;
    end

    // leading-zero count of the IBM fraction
    always_comb begin
        n_lzc2 = 5'd0;
        for (int i = 0; i < 24; i++) begin
            if (r_w1[i]) begin
                n_lzc2 = 5'(23 - i);
            end
        end
    end

    // IEEE to IBM: align exponent to a multiple of four
    always_comb begin
        u_exp     = {1'b0, r_w1[30:23]} + 9'd2;
        u_shift   = 2'(-u_exp[1:0]);
        u_aligned = u_exp + {7'd0, u_shift};
        u_hexexp  = u_aligned[8:2] + IBM_EXP_OFS;
        if (r_w1 == 32'd0) begin
            n_ibm2 = 32'd0;
        end else begin
            n_ibm2 = {r_w1[31], u_hexexp, {1'b1, r_w1[22:0]} >> u_shift};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
        r_func2  <= r_func1;
        r_swap2  <= r_swap1;
        r_sign2  <= r_w1[31];
        r_exp2   <= r_w1[30:24];
        r_frac2  <= r_w1[23:0];
        r_zword2 <= (r_w1 == 32'd0);
        r_zfrac2 <= (r_w1[23:0] == 24'd0);
        r_lzc2   <= n_lzc2;
        r_ibm2   <= n_ibm2;
    end

    // stage 3: normalise, range check and pack
    always_comb begin
        e_bin     = signed'({1'b0, r_exp2, 2'b00}) - signed'(IBM_EXP_BIAS)
                    - signed'({5'd0, r_lzc2});
        norm_frac = r_frac2 << r_lzc2;
        n_res3.status = ST_NORMAL;
        if (r_func2 == FUNC_IEEE2IBM) begin
            n_res3.word_out = r_swap2 ? bswap32(r_ibm2) : r_ibm2;
        end else if (r_zword2) begin
            n_res3.word_out = 32'd0;
        end else if (r_zfrac2) begin
            n_res3.word_out = QNAN_WORD;
            n_res3.status   = ST_NAN;
        end else if (e_bin > signed'(IEEE_EXP_MAX)) begin
            n_res3.word_out = {r_sign2, MAX_FINITE};
            n_res3.status   = ST_SAT;
        end else if (e_bin <= 10'sd0) begin
            n_res3.word_out = 32'd0;
            n_res3.status   = ST_UNDER;
        end else begin
            n_res3.word_out = {r_sign2, e_bin[7:0], norm_frac[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
        r_res3 <= n_res3;
    end

endmodule

### hw/rtl/ifc_check.sv
// ----------------------------------------------------------------------------
// ifc_check
// Port-level checks on the converter, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ifc_check
    import ifc_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_strobe,
    input t_out_item o_result
);

    // every accepted item gives a result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##3 o_strobe)
        else $error("result missing three cycles after start transfer");

    // no result without an earlier matching start transfer
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(i_start && !o_busy, 3))
        else $error("result strobe without matching start transfer");

    // nan status carries the quiet nan word
    a_nan_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_NAN) |-> o_result.word_out == QNAN_WORD)
        else $error("nan status with wrong word");

    // saturation gives the largest finite magnitude
    a_sat_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_SAT) |-> o_result.word_out[30:0] == MAX_FINITE)
        else $error("saturation status with wrong magnitude");

    // underflow flushes to plus zero
    a_under_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_UNDER) |-> o_result.word_out == 32'd0)
        else $error("underflow status with nonzero word");

endmodule

bind ibm_ieee_float32_convert_top ifc_check u_ifc_check (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (i_start),
    .o_busy   (o_busy),
    .o_strobe (o_strobe),
    .o_result (o_result)
);
